// ===== rtl/core/cpg_pkg.sv =====
// shared types and constants for the cosine profile position generator
// no dependencies; imported by every module of the block

package cpg_pkg;

   // command codes carried by an input item
   typedef enum logic [1:0] {
      CMD_TICK = 2'd0,
      CMD_DIR  = 2'd1,
      CMD_LOAD = 2'd2
   } cmd_type;

   // configuration register indexes
   typedef enum logic {
      CSR_UP_POSITION   = 1'b0,
      CSR_DOWN_POSITION = 1'b1
   } csr_index_type;

   // reset values of the target registers (truncated to the position width)
   localparam int unsigned UP_POSITION_RESET   = 3235;
   localparam int unsigned DOWN_POSITION_RESET = 2090;

   // fixed point format used while building the fraction table
   localparam int unsigned ANGLE_BITS   = 28;
   localparam int unsigned TAYLOR_TERMS = 12;

endpackage

// ===== rtl/core/cpg_cfg.sv =====
// target position registers written through the csr port
// depends on cpg_pkg for register indexes and reset values

module cpg_cfg
   import cpg_pkg::*;
#(
   parameter int unsigned POSITION_BITS = 12
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic                     csr_index,
   input  logic [POSITION_BITS-1:0] csr_wdata,
   output logic [POSITION_BITS-1:0] up_position,
   output logic [POSITION_BITS-1:0] down_position
);

   logic [POSITION_BITS-1:0] up_ff,   up_in;
   logic [POSITION_BITS-1:0] down_ff, down_in;

   // register write decode
   always_comb begin
      up_in   = up_ff;
      down_in = down_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_UP_POSITION:   up_in   = csr_wdata;
            CSR_DOWN_POSITION: down_in = csr_wdata;
            default:           up_in   = up_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         up_ff   <= POSITION_BITS'(UP_POSITION_RESET);
         down_ff <= POSITION_BITS'(DOWN_POSITION_RESET);
      end else begin
         up_ff   <= up_in;
         down_ff <= down_in;
      end
   end

   assign up_position   = up_ff;
   assign down_position = down_ff;

endmodule

// ===== rtl/core/cpg_frac_rom.sv =====
// raised-cosine fraction table, 0.5*(1-cos(pi*k/N)) in unsigned fixed point
// built at elaboration from a Taylor series; depends on cpg_pkg

module cpg_frac_rom
   import cpg_pkg::*;
#(
   parameter int unsigned PROFILE_STEPS = 150,
   parameter int unsigned FRACTION_BITS = 16,
   localparam int unsigned IDX_W = $clog2(PROFILE_STEPS + 1)
) (
   input  logic [IDX_W-1:0]       index,
   output logic [FRACTION_BITS:0] fraction
);

   // Q28 and Q16 helpers shared by every entry
   localparam logic [63:0]        ONE       = 64'd1 << ANGLE_BITS;
   localparam logic [63:0]        THETA_DIV = 64'd10000 * 64'(PROFILE_STEPS);
   localparam logic [63:0]        FULL      = 64'd1 << FRACTION_BITS;
   localparam logic signed [63:0] ONE_S     = signed'(ONE);
   localparam logic signed [63:0] TWO_S     = 64'sd2 * ONE_S;

   logic [FRACTION_BITS:0] rom [0:PROFILE_STEPS];

   // constant entries, integer arithmetic only, twelve Taylor terms of the cosine
   for (genvar g = 0; g <= PROFILE_STEPS; g++) begin : g_rom
      localparam logic [63:0] THETA = (64'd31415 * ONE * 64'(g)) / THETA_DIV;
      localparam logic [63:0] X2    = (THETA * THETA) >> ANGLE_BITS;
      localparam logic [63:0] T1    = ((ONE * X2) >> ANGLE_BITS) / 64'd2;
      localparam logic [63:0] T2    = ((T1 * X2) >> ANGLE_BITS) / 64'd12;
      localparam logic [63:0] T3    = ((T2 * X2) >> ANGLE_BITS) / 64'd30;
      localparam logic [63:0] T4    = ((T3 * X2) >> ANGLE_BITS) / 64'd56;
      localparam logic [63:0] T5    = ((T4 * X2) >> ANGLE_BITS) / 64'd90;
      localparam logic [63:0] T6    = ((T5 * X2) >> ANGLE_BITS) / 64'd132;
      localparam logic [63:0] T7    = ((T6 * X2) >> ANGLE_BITS) / 64'd182;
      localparam logic [63:0] T8    = ((T7 * X2) >> ANGLE_BITS) / 64'd240;
      localparam logic [63:0] T9    = ((T8 * X2) >> ANGLE_BITS) / 64'd306;
      localparam logic [63:0] T10   = ((T9 * X2) >> ANGLE_BITS) / 64'd380;
      localparam logic [63:0] T11   = ((T10 * X2) >> ANGLE_BITS) / 64'd462;
      localparam logic [63:0] T12   = ((T11 * X2) >> ANGLE_BITS) / 64'd552;
      localparam logic signed [63:0] COSV =
         ONE_S - signed'(T1) + signed'(T2) - signed'(T3) + signed'(T4)
         - signed'(T5) + signed'(T6) - signed'(T7) + signed'(T8)
         - signed'(T9) + signed'(T10) - signed'(T11) + signed'(T12);
      localparam logic signed [63:0] D_RAW = ONE_S - COSV;
      localparam logic signed [63:0] D =
         (D_RAW < 64'sd0) ? 64'sd0 : ((D_RAW > TWO_S) ? TWO_S : D_RAW);
      localparam logic [63:0] F_RAW =
         (unsigned'(D) + (64'd1 << (ANGLE_BITS - FRACTION_BITS)))
         >> (ANGLE_BITS + 1 - FRACTION_BITS);
      localparam logic [63:0] F = (F_RAW > FULL) ? FULL : F_RAW;
      assign rom[g] = F[FRACTION_BITS:0];
   end

   // lookup; indexes past the last step read zero
   always_comb begin
      if (32'(index) <= PROFILE_STEPS) begin
         fraction = rom[index];
      end else begin
         fraction = '0;
      end
   end

endmodule

// ===== rtl/core/cpg_engine.sv =====
// profile state registers and per-item next-state logic
// depends on cpg_pkg and cpg_frac_rom

module cpg_engine
   import cpg_pkg::*;
#(
   parameter int unsigned PROFILE_STEPS = 150,
   parameter int unsigned FRACTION_BITS = 16,
   parameter int unsigned POSITION_BITS = 12
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     fire,
   input  logic [1:0]               cmd,
   input  logic                     direction,
   input  logic [POSITION_BITS-1:0] measured_position,
   input  logic [POSITION_BITS-1:0] up_position,
   input  logic [POSITION_BITS-1:0] down_position,
   output logic [POSITION_BITS-1:0] position,
   output logic                     moving
);

   localparam int unsigned STEP_W = $clog2(PROFILE_STEPS + 2);
   localparam int unsigned IDX_W  = $clog2(PROFILE_STEPS + 1);
   localparam int unsigned PROD_W = FRACTION_BITS + POSITION_BITS + 3;
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(PROFILE_STEPS);

   logic [POSITION_BITS-1:0] cur_ff,   cur_in;
   logic [POSITION_BITS-1:0] start_ff, start_in;
   logic [STEP_W-1:0]        step_ff,  step_in;
   logic                     dir_ff,   dir_in;

   logic [FRACTION_BITS:0]          fraction;
   logic [POSITION_BITS-1:0]        target;
   logic signed [POSITION_BITS:0]   diff;
   logic signed [PROD_W-1:0]        prod;
   logic signed [PROD_W-1:0]        delta;
   logic [POSITION_BITS-1:0]        point;

   cpg_frac_rom #(
      .PROFILE_STEPS (PROFILE_STEPS),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_rom (
      .index    (step_ff[IDX_W-1:0]),
      .fraction (fraction)
   );

   // profile point: start + floor(frac * (target - start) / 2^F)
   always_comb begin
      target = dir_ff ? up_position : down_position;
      diff   = $signed({1'b0, target}) - $signed({1'b0, start_ff});
      prod   = PROD_W'($signed({1'b0, fraction})) * PROD_W'(diff);
      delta  = prod >>> FRACTION_BITS;
      point  = start_ff + delta[POSITION_BITS-1:0];
   end

   // command decode and state update
   always_comb begin
      cur_in   = cur_ff;
      start_in = start_ff;
      step_in  = step_ff;
      dir_in   = dir_ff;
      moving   = 1'b0;
      case (cmd_type'(cmd))
         CMD_DIR: begin
            if (direction != dir_ff) begin
               start_in = cur_ff;
               dir_in   = direction;
               step_in  = '0;
            end
         end
         CMD_LOAD: begin
            cur_in   = measured_position;
            start_in = measured_position;
            step_in  = '0;
         end
         CMD_TICK: begin
            if (step_ff <= LAST_STEP) begin
               if (step_ff == LAST_STEP) begin
                  cur_in = target;
               end else begin
                  cur_in = point;
                  moving = 1'b1;
               end
               step_in = step_ff + 1'b1;
            end
         end
         default: begin
            cur_in = cur_ff;
         end
      endcase
   end

   assign position = cur_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff   <= '0;
         start_ff <= '0;
         step_ff  <= '0;
         dir_ff   <= 1'b0;
      end else if (fire) begin
         cur_ff   <= cur_in;
         start_ff <= start_in;
         step_ff  <= step_in;
         dir_ff   <= dir_in;
      end
   end

endmodule

// ===== rtl/core/cosine_profile_position_generator.sv =====
// cosine profile position generator, top level
// throughput: one item per cycle, but a tick stalls while the result register is full
// and rsp_ready is low; each item takes one table read and one multiply
// in the engine stage between the input register and the result register
// reset: synchronous, clears profile state and handshakes, targets take defaults
// depends on cpg_pkg, cpg_cfg, cpg_engine

module cosine_profile_position_generator
   import cpg_pkg::*;
#(
   parameter int unsigned PROFILE_STEPS = 150,
   parameter int unsigned FRACTION_BITS = 16,
   parameter int unsigned POSITION_BITS = 12
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [1:0]               req_cmd,
   input  logic                     req_direction,
   input  logic [POSITION_BITS-1:0] req_measured_position,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [POSITION_BITS-1:0] rsp_position,
   output logic                     rsp_moving,
   input  logic                     csr_we,
   input  logic                     csr_index,
   input  logic [POSITION_BITS-1:0] csr_wdata
);

   logic                     s1_valid_ff, s1_valid_in;
   logic [1:0]               s1_cmd_ff;
   logic                     s1_dir_ff;
   logic [POSITION_BITS-1:0] s1_meas_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [POSITION_BITS-1:0] rsp_pos_ff;
   logic                     rsp_moving_ff;

   logic                     s1_is_tick;
   logic                     s1_fire;
   logic                     req_take;
   logic [POSITION_BITS-1:0] up_position;
   logic [POSITION_BITS-1:0] down_position;
   logic [POSITION_BITS-1:0] eng_position;
   logic                     eng_moving;

   cpg_cfg #(
      .POSITION_BITS (POSITION_BITS)
   ) u_cfg (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .up_position   (up_position),
      .down_position (down_position)
   );

   cpg_engine #(
      .PROFILE_STEPS (PROFILE_STEPS),
      .FRACTION_BITS (FRACTION_BITS),
      .POSITION_BITS (POSITION_BITS)
   ) u_engine (
      .clock             (clock),
      .reset             (reset),
      .fire              (s1_fire),
      .cmd               (s1_cmd_ff),
      .direction         (s1_dir_ff),
      .measured_position (s1_meas_ff),
      .up_position       (up_position),
      .down_position     (down_position),
      .position          (eng_position),
      .moving            (eng_moving)
   );

   // flow control: only a tick item needs room in the result register
   always_comb begin
      s1_is_tick  = (s1_cmd_ff == CMD_TICK);
      s1_fire     = s1_valid_ff && (!s1_is_tick || !rsp_valid_ff || rsp_ready);
      req_ready   = !s1_valid_ff || s1_fire;
      req_take    = req_valid && req_ready;
      s1_valid_in = req_take || (s1_valid_ff && !s1_fire);
      if (s1_fire && s1_is_tick) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // handshake state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // input item register
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_cmd_ff  <= req_cmd;
         s1_dir_ff  <= req_direction;
         s1_meas_ff <= req_measured_position;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (s1_fire && s1_is_tick) begin
         rsp_pos_ff    <= eng_position;
         rsp_moving_ff <= eng_moving;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_position = rsp_pos_ff;
   assign rsp_moving   = rsp_moving_ff;

endmodule

// ===== tb/tb_cosine_profile_position_generator.sv =====
// testbench for the cosine profile position generator: directed table, then random
// command sequences under several idle and stall patterns, checked by a set-point predictor
// depends on cpg_pkg and cosine_profile_position_generator
`timescale 1ns / 100ps

module tb_cosine_profile_position_generator;
   import cpg_pkg::*;

   localparam int STEPS         = 150;
   localparam int FRAC_BITS     = 16;
   localparam int POS_BITS      = 12;
   localparam int LIMIT_CYCLES  = 300000;
   localparam int HOLD_CYCLES   = 300;
   // a tick item passes through the input register and the result register of the block
   localparam int SETTLE_CYCLES = 4;
   localparam int DRAIN_CYCLES  = 8;
   localparam int DRILL_ROWS    = 23;
   localparam int RANDOM_QUOTA  = 110;

   // command code the block leaves unused
   localparam logic [1:0]          CMD_UNUSED = 2'd3;
   localparam logic [POS_BITS-1:0] POS_MAX    = '1;
   localparam logic [POS_BITS-1:0] POS_MIN    = '0;
   localparam logic [POS_BITS-1:0] UP_RESET   = POS_BITS'(UP_POSITION_RESET);
   localparam logic [POS_BITS-1:0] DOWN_RESET = POS_BITS'(DOWN_POSITION_RESET);

   typedef struct packed {
      logic [POS_BITS-1:0] position;
      logic                moving;
   } setpoint_t;

   // one row of the directed table; fixed rows carry a hand-written set point
   typedef struct packed {
      logic [1:0]          cmd;
      logic                direction;
      logic [POS_BITS-1:0] measured;
      logic [7:0]          reps;
      logic                fixed;
      logic [POS_BITS-1:0] fixed_position;
      logic                fixed_moving;
   } drill_row_t;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [1:0]          req_cmd = CMD_TICK;
   logic                req_direction = 1'b0;
   logic [POS_BITS-1:0] req_measured_position = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [POS_BITS-1:0] rsp_position;
   logic                rsp_moving;
   logic                csr_we = 1'b0;
   logic                csr_index = CSR_UP_POSITION;
   logic [POS_BITS-1:0] csr_wdata = '0;

   // hand-written set point travelling alongside the item on the wire
   logic                drv_fixed = 1'b0;
   logic [POS_BITS-1:0] drv_fixed_position = '0;
   logic                drv_fixed_moving = 1'b0;

   // set-point predictor state and its copy of the targets
   longint unsigned     frac_table [0:STEPS];
   logic [POS_BITS-1:0] model_position = '0;
   logic [POS_BITS-1:0] model_start = '0;
   int                  model_step = 0;
   logic                model_dir = 1'b0;
   logic [POS_BITS-1:0] target_up = UP_RESET;
   logic [POS_BITS-1:0] target_down = DOWN_RESET;
   setpoint_t           expected_setpoints [$];

   drill_row_t          drill_rows [0:DRILL_ROWS-1];
   int                  req_idle_pct = 0;
   int                  rsp_stall_pct = 0;
   logic                hold_arm = 1'b0;
   int                  hold_left = 0;
   int                  cycle_count = 0;
   int                  errors = 0;
   int                  items_sent = 0;
   int                  setpoints_checked = 0;
   int                  moves_done = 0;
   int                  target_settings = 1;

   cosine_profile_position_generator u_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_cmd               (req_cmd),
      .req_direction         (req_direction),
      .req_measured_position (req_measured_position),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_position          (rsp_position),
      .rsp_moving            (rsp_moving),
      .csr_we                (csr_we),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata)
   );

   always #6 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("simulation failed");
         $finish;
      end
   end

   // result side ready: random stalls, plus one long hold-off when armed
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
         if (hold_arm)
            hold_left <= HOLD_CYCLES;
      end
   end

   // follow every accepted item and predict the set point of each tick
   always @(posedge clock) begin : predict_setpoint
      logic [POS_BITS-1:0] aim;
      longint              prod;
      setpoint_t           sp;
      if (!reset && req_valid && req_ready) begin
         case (req_cmd)
            CMD_DIR: begin
               // only a real change of direction restarts the move
               if (req_direction != model_dir) begin
                  model_start = model_position;
                  model_dir   = req_direction;
                  model_step  = 0;
               end
            end
            CMD_LOAD: begin
               model_position = req_measured_position;
               model_start    = req_measured_position;
               model_step     = 0;
            end
            CMD_TICK: begin
               sp.moving = 1'b0;
               if (model_step <= STEPS) begin
                  aim = model_dir ? target_up : target_down;
                  if (model_step == STEPS) begin
                     // last step lands exactly on the target
                     model_position = aim;
                     moves_done++;
                  end else begin
                     // floor of the scaled distance, also for downward moves
                     prod = longint'(frac_table[model_step]) *
                            (longint'(aim) - longint'(model_start));
                     model_position = POS_BITS'(longint'(model_start) + (prod >>> FRAC_BITS));
                     sp.moving = 1'b1;
                  end
                  model_step++;
               end
               sp.position = model_position;
               if (drv_fixed) begin
                  sp.position = drv_fixed_position;
                  sp.moving   = drv_fixed_moving;
               end
               expected_setpoints.push_back(sp);
            end
            default: ;
         endcase
      end
   end

   // compare every delivered set point with the oldest expectation
   always @(posedge clock) begin : check_setpoint
      setpoint_t want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_setpoints.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("cycle %0d: unexpected set point position %0d moving %0d",
                        cycle_count, rsp_position, rsp_moving);
         end else begin
            want = expected_setpoints.pop_front();
            setpoints_checked++;
            if (rsp_position !== want.position || rsp_moving !== want.moving) begin
               errors++;
               if (errors <= 10)
                  $display("cycle %0d: expected position %0d moving %0d, got position %0d moving %0d",
                           cycle_count, want.position, want.moving, rsp_position, rsp_moving);
            end
         end
      end
   end

   // offer one item after a random gap and wait until it is taken
   task automatic send_item(input logic [1:0] c, input logic d, input logic [POS_BITS-1:0] m,
                            input logic fx, input logic [POS_BITS-1:0] fp, input logic fm);
      int gap;
      gap = 0;
      while ($urandom_range(99) < req_idle_pct)
         gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid             <= 1'b1;
      req_cmd               <= c;
      req_direction         <= d;
      req_measured_position <= m;
      drv_fixed             <= fx;
      drv_fixed_position    <= fp;
      drv_fixed_moving      <= fm;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      items_sent++;
   endtask

   task automatic wait_drained();
      while (expected_setpoints.size() != 0)
         @(posedge clock);
   endtask

   // retarget both positions while nothing is in flight
   task automatic write_targets(input logic [POS_BITS-1:0] up, input logic [POS_BITS-1:0] down);
      req_valid <= 1'b0;
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_UP_POSITION;
      csr_wdata <= up;
      @(posedge clock);
      csr_index <= CSR_DOWN_POSITION;
      csr_wdata <= down;
      @(posedge clock);
      csr_we      <= 1'b0;
      target_up   = up;
      target_down = down;
      target_settings++;
   endtask

   // random command sequences: an optional leading command, then a run of ticks,
   // often long enough to finish the move and idle past its end
   task automatic run_random(input int quota);
      int                  counted;
      int                  pick;
      int                  run_len;
      logic [POS_BITS-1:0] m;
      counted = 0;
      while (counted < quota) begin
         pick = $urandom_range(99);
         m = ($urandom_range(3) == 0) ? ($urandom_range(1) ? POS_MAX : POS_MIN)
                                      : POS_BITS'($urandom);
         if (pick < 40)
            send_item(CMD_DIR, 1'($urandom_range(1)), POS_BITS'($urandom), 1'b0, '0, 1'b0);
         else if (pick < 60) begin
            send_item(CMD_LOAD, 1'($urandom_range(1)), m, 1'b0, '0, 1'b0);
            counted++;
         end else if (pick < 68)
            send_item(CMD_UNUSED, 1'($urandom_range(1)), POS_BITS'($urandom), 1'b0, '0, 1'b0);
         run_len = ($urandom_range(99) < 30) ? $urandom_range(STEPS + 1, STEPS + 20)
                                             : $urandom_range(1, 40);
         repeat (run_len) begin
            send_item(CMD_TICK, 1'($urandom_range(1)), POS_BITS'($urandom), 1'b0, '0, 1'b0);
            counted++;
         end
      end
   endtask

   initial begin
      longint unsigned one;
      longint unsigned theta;
      longint unsigned x2;
      longint unsigned term;
      longint unsigned frac;
      longint          cos_sum;
      longint          lift;
      int              k;
      int              n;
      int              r;

      // raised-cosine fraction table, Q28 Taylor series rounded to Q16
      one = 64'd1 << ANGLE_BITS;
      for (k = 0; k <= STEPS; k++) begin
         theta = (64'd31415 * one * 64'(k)) / (64'd10000 * 64'(STEPS));
         x2 = (theta * theta) >> ANGLE_BITS;
         term = one;
         cos_sum = longint'(one);
         for (n = 1; n <= TAYLOR_TERMS; n++) begin
            term = ((term * x2) >> ANGLE_BITS) / 64'((2 * n - 1) * (2 * n));
            if (n % 2 == 1)
               cos_sum -= longint'(term);
            else
               cos_sum += longint'(term);
         end
         lift = longint'(one) - cos_sum;
         if (lift < 0)
            lift = 0;
         if (lift > 2 * longint'(one))
            lift = 2 * longint'(one);
         frac = ($unsigned(lift) + (64'd1 << (ANGLE_BITS - FRAC_BITS))) >>
                (ANGLE_BITS + 1 - FRAC_BITS);
         if (frac > (64'd1 << FRAC_BITS))
            frac = 64'd1 << FRAC_BITS;
         frac_table[k] = frac;
      end

      // cmd, direction, measured, reps, fixed, fixed position, fixed moving
      drill_rows = '{
         '{CMD_TICK,   1'b0, POS_MIN, 8'd1,   1'b1, POS_MIN,    1'b1}, // first tick after reset
         '{CMD_UNUSED, 1'b1, POS_MAX, 8'd1,   1'b0, POS_MIN,    1'b0}, // unused command ignored
         '{CMD_DIR,    1'b0, POS_MIN, 8'd1,   1'b0, POS_MIN,    1'b0}, // same direction, no restart
         '{CMD_TICK,   1'b0, POS_MIN, 8'd1,   1'b0, POS_MIN,    1'b0},
         '{CMD_LOAD,   1'b0, POS_MAX, 8'd1,   1'b0, POS_MIN,    1'b0},
         '{CMD_TICK,   1'b1, POS_MIN, 8'd1,   1'b1, POS_MAX,    1'b1}, // restart at loaded value
         '{CMD_TICK,   1'b0, POS_MAX, 8'd1,   1'b0, POS_MIN,    1'b0}, // downward, floor rounding
         '{CMD_DIR,    1'b1, POS_MIN, 8'd1,   1'b0, POS_MIN,    1'b0}, // turn around mid-move
         '{CMD_TICK,   1'b0, POS_MIN, 8'd20,  1'b0, POS_MIN,    1'b0},
         '{CMD_LOAD,   1'b1, POS_MIN, 8'd1,   1'b0, POS_MIN,    1'b0},
         '{CMD_DIR,    1'b0, POS_MAX, 8'd1,   1'b0, POS_MIN,    1'b0},
         '{CMD_TICK,   1'b0, POS_MIN, 8'd150, 1'b0, POS_MIN,    1'b0}, // whole profile
         '{CMD_TICK,   1'b1, POS_MAX, 8'd1,   1'b1, DOWN_RESET, 1'b0}, // last step on target
         '{CMD_TICK,   1'b0, POS_MIN, 8'd1,   1'b1, DOWN_RESET, 1'b0}, // held after the end
         '{CMD_DIR,    1'b0, POS_MIN, 8'd1,   1'b0, POS_MIN,    1'b0},
         '{CMD_TICK,   1'b0, POS_MIN, 8'd1,   1'b1, DOWN_RESET, 1'b0},
         '{CMD_DIR,    1'b1, POS_MIN, 8'd1,   1'b0, POS_MIN,    1'b0}, // up from rest
         '{CMD_TICK,   1'b1, POS_MAX, 8'd5,   1'b0, POS_MIN,    1'b0},
         '{CMD_LOAD,   1'b0, POS_MAX, 8'd1,   1'b0, POS_MIN,    1'b0}, // load mid-move
         '{CMD_TICK,   1'b0, POS_MIN, 8'd1,   1'b1, POS_MAX,    1'b1},
         '{CMD_UNUSED, 1'b0, POS_MIN, 8'd1,   1'b0, POS_MIN,    1'b0},
         '{CMD_TICK,   1'b1, POS_MAX, 8'd3,   1'b0, POS_MIN,    1'b0},
         '{CMD_LOAD,   1'b1, POS_MIN, 8'd1,   1'b0, POS_MIN,    1'b0}
      };

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed items against the reset targets
      for (r = 0; r < DRILL_ROWS; r++)
         repeat (drill_rows[r].reps)
            send_item(drill_rows[r].cmd, drill_rows[r].direction, drill_rows[r].measured,
                      drill_rows[r].fixed, drill_rows[r].fixed_position,
                      drill_rows[r].fixed_moving);

      // full scale targets, no idling
      write_targets(POS_MAX, POS_MIN);
      run_random(RANDOM_QUOTA);

      // up below down, sender idling
      write_targets(POS_MIN, POS_MAX);
      req_idle_pct = 51;
      run_random(RANDOM_QUOTA);

      // random targets, receiver stalling, one long hold-off to back up the input
      write_targets(POS_BITS'($urandom), POS_BITS'($urandom));
      req_idle_pct  = 0;
      rsp_stall_pct = 51;
      hold_arm <= 1'b1;
      @(posedge clock);
      hold_arm <= 1'b0;
      run_random(RANDOM_QUOTA);

      // random targets, both sides idling
      write_targets(POS_BITS'($urandom), POS_BITS'($urandom));
      req_idle_pct  = 26;
      rsp_stall_pct = 26;
      run_random(RANDOM_QUOTA);

      req_valid <= 1'b0;
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      errors += expected_setpoints.size();

      $display("%0d items over %0d target settings and four handshake patterns",
               items_sent, target_settings);
      $display("%0d set points compared, %0d moves run to their target, %0d errors",
               setpoints_checked, moves_done, errors);
      if (errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/cpg_pkg.sv
rtl/core/cpg_cfg.sv
rtl/core/cpg_frac_rom.sv
rtl/core/cpg_engine.sv
rtl/core/cosine_profile_position_generator.sv
tb/tb_cosine_profile_position_generator.sv
